// ===== sv/ipdf_pkg.sv =====
`default_nettype none

package ipdf_pkg;

  // Inner header bytes gathered before the version decision
  localparam int unsigned GATHER_MAX    = 6;
  localparam int unsigned CNT_W         = $clog2(GATHER_MAX + 1);
  localparam int unsigned BASIC_HDR_LEN = 4;
  localparam int unsigned CC_HDR_LEN    = 24;
  localparam int unsigned IPV6_HDR_LEN  = 40;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam logic [7:0] SUBTYPE_BASIC = 8'h00;
  localparam logic [7:0] SUBTYPE_CC    = 8'h01;

  localparam logic [3:0] VER_PAD  = 4'h0;
  localparam logic [3:0] VER_IPV4 = 4'h4;
  localparam logic [3:0] VER_IPV6 = 4'h6;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_OUTER = 3'd1,
    ST_BAD_VER   = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_TOO_SHORT = 3'd4
  } status_e;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HDR    = 6'b000010,
    PH_CC     = 6'b000100,
    PH_GATHER = 6'b001000,
    PH_BODY   = 6'b010000,
    PH_DROP   = 6'b100000
  } phase_e;

  typedef logic [GATHER_MAX-1:0][7:0] hdr_buf_t;

  // One queued burst: cnt bytes, then an optional status word
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    hdr_buf_t         data;
    logic             start;
    logic             end_last;
    logic             v6;
    logic             has_stat;
    status_e          stat;
  } job_t;

endpackage

`default_nettype wire

// ===== sv/ipdf_in_if.sv =====
`default_nettype none

interface ipdf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first;
  logic [15:0] outer_len;

  modport source (output valid, data_byte, first, outer_len, input ready);
  modport sink   (input valid, data_byte, first, outer_len, output ready);
endinterface

`default_nettype wire

// ===== sv/ipdf_out_if.sv =====
`default_nettype none

interface ipdf_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic       inner_start;
  logic       inner_end;
  logic       inner_is_v6;
  logic [2:0] status;
  logic       run_last;

  modport source (output valid, kind, out_byte, inner_start, inner_end, inner_is_v6,
                  status, run_last, input ready);
  modport sink   (input valid, kind, out_byte, inner_start, inner_end, inner_is_v6,
                  status, run_last, output ready);
endinterface

`default_nettype wire

// ===== sv/ipdf_fifo.sv =====
`default_nettype none

module ipdf_fifo #(
  parameter int unsigned Depth = ipdf_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ipdf_pkg::job_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output ipdf_pkg::job_t      data_o
);
  import ipdf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ipdf_front.sv =====
`default_nettype none

module ipdf_front (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ipdf_in_if.sink        in_i,
  input  wire logic      q_full_i,
  output logic           push_o,
  output ipdf_pkg::job_t job_o
);
  import ipdf_pkg::*;

  phase_e           phase_q, phase_d, ph_s;
  logic [15:0]      bol_q, bol_d, bol_s, bol_n;
  logic [4:0]       hpos_q, hpos_d, hpos_s;
  logic [7:0]       sub_q, sub_d, sub_s;
  hdr_buf_t         hbuf_q, hbuf_d, hbuf_w;
  logic [CNT_W-1:0] hcnt_q, hcnt_d, hcnt_s, cnt_w;
  logic [15:0]      ibl_q, ibl_d, ibl_s, ibl_n;
  status_e          pst_q, pst_d, pst_s;

  logic        acc;
  logic [7:0]  b;
  logic [3:0]  ver;
  logic        ver6;
  logic [16:0] rem, iplen;
  logic [5:0]  hl;

  assign in_i.ready = !q_full_i;
  assign acc        = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;

  // Start-of-payload values: a first byte restarts the parser
  always_comb begin
    ph_s   = phase_q;
    bol_s  = bol_q;
    hpos_s = hpos_q;
    sub_s  = sub_q;
    hcnt_s = hcnt_q;
    ibl_s  = ibl_q;
    pst_s  = pst_q;
    if (in_i.first) begin
      ph_s   = PH_HDR;
      bol_s  = (in_i.outer_len == '0) ? 16'd1 : in_i.outer_len;
      hpos_s = '0;
      sub_s  = '0;
      hcnt_s = '0;
      ibl_s  = '0;
      pst_s  = ST_OK;
    end
  end

  assign bol_n = bol_s - 16'd1;
  assign ibl_n = ibl_s - 16'd1;

  // Header buffer with the current byte merged in at the gather position
  always_comb begin
    for (int i = 0; i < GATHER_MAX; i++) begin
      hbuf_w[i] = (hcnt_q == CNT_W'(i)) ? b : hbuf_q[i];
    end
  end

  assign cnt_w = hcnt_q + 1'b1;
  assign ver   = hbuf_w[0][7:4];
  assign ver6  = (ver == VER_IPV6);
  assign rem   = 17'(cnt_w) + 17'(bol_n);
  assign iplen = ver6 ? (17'({hbuf_w[4], hbuf_w[5]}) + 17'(IPV6_HDR_LEN))
                      : 17'({hbuf_w[2], hbuf_w[3]});
  assign hl    = ver6 ? 6'(IPV6_HDR_LEN) : {hbuf_w[0][3:0], 2'b00};

  always_comb begin
    phase_d = phase_q;
    bol_d   = bol_q;
    hpos_d  = hpos_q;
    sub_d   = sub_q;
    hbuf_d  = hbuf_q;
    hcnt_d  = hcnt_q;
    ibl_d   = ibl_q;
    pst_d   = pst_q;
    push_o  = 1'b0;
    job_o   = '0;
    if (acc) begin
      if (!in_i.first && (phase_q == PH_IDLE || bol_q == '0)) begin
        phase_d = PH_IDLE;
      end else begin
        phase_d = ph_s;
        bol_d   = bol_n;
        hpos_d  = hpos_s;
        sub_d   = sub_s;
        hcnt_d  = hcnt_s;
        ibl_d   = ibl_s;
        pst_d   = pst_s;
        unique case (ph_s)
          PH_HDR: begin
            if (hpos_s == '0) begin
              sub_d = b;
            end
            if (hpos_s != '0 && b != '0) begin
              pst_d   = ST_BAD_OUTER;
              phase_d = PH_DROP;
            end else begin
              hpos_d = hpos_s + 1'b1;
              if (hpos_d == 5'(BASIC_HDR_LEN)) begin
                if (sub_d == SUBTYPE_CC) begin
                  phase_d = PH_CC;
                end else if (sub_d == SUBTYPE_BASIC) begin
                  phase_d = PH_GATHER;
                  hcnt_d  = '0;
                end else begin
                  pst_d   = ST_BAD_OUTER;
                  phase_d = PH_DROP;
                end
              end
            end
          end
          PH_CC: begin
            hpos_d = hpos_s + 1'b1;
            if (hpos_d >= 5'(CC_HDR_LEN)) begin
              phase_d = PH_GATHER;
              hcnt_d  = '0;
            end
          end
          PH_GATHER: begin
            hbuf_d = hbuf_w;
            hcnt_d = cnt_w;
            if (cnt_w == CNT_W'(GATHER_MAX) || bol_n == '0) begin
              if (ver == VER_IPV4 && cnt_w < CNT_W'(4)) begin
                pst_d   = ST_BAD_OUTER;
                phase_d = PH_DROP;
              end else if (ver6 && cnt_w < CNT_W'(GATHER_MAX)) begin
                pst_d   = ST_BAD_OUTER;
                phase_d = PH_DROP;
              end else if (ver == VER_PAD) begin
                phase_d = PH_DROP;
              end else if (ver != VER_IPV4 && !ver6) begin
                pst_d   = ST_BAD_VER;
                phase_d = PH_DROP;
              end else if (iplen > rem || 17'(hl) > rem) begin
                pst_d   = ST_TOO_LONG;
                phase_d = PH_DROP;
              end else if (iplen < 17'(hl) || iplen < 17'(cnt_w)) begin
                pst_d   = ST_TOO_SHORT;
                phase_d = PH_DROP;
              end else begin
                push_o         = 1'b1;
                job_o.cnt      = cnt_w;
                job_o.data     = hbuf_w;
                job_o.start    = 1'b1;
                job_o.end_last = (iplen == 17'(cnt_w));
                job_o.v6       = ver6;
                ibl_d          = 16'(iplen - 17'(cnt_w));
                hcnt_d         = '0;
                phase_d        = (iplen == 17'(cnt_w)) ? PH_GATHER : PH_BODY;
              end
            end
          end
          PH_BODY: begin
            ibl_d          = ibl_n;
            push_o         = 1'b1;
            job_o.cnt      = CNT_W'(1);
            job_o.data[0]  = b;
            job_o.end_last = (ibl_n == '0);
            job_o.v6       = (hbuf_q[0][7:4] == VER_IPV6);
            if (ibl_n == '0) begin
              phase_d = PH_GATHER;
              hcnt_d  = '0;
            end
          end
          default: begin
          end
        endcase
        if (bol_n == '0) begin
          if (phase_d == PH_HDR || phase_d == PH_CC) begin
            pst_d = ST_BAD_OUTER;
          end
          push_o         = 1'b1;
          job_o.has_stat = 1'b1;
          job_o.stat     = pst_d;
          phase_d        = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bol_q   <= '0;
      hpos_q  <= '0;
      sub_q   <= '0;
      hcnt_q  <= '0;
      ibl_q   <= '0;
      pst_q   <= ST_OK;
    end else begin
      phase_q <= phase_d;
      bol_q   <= bol_d;
      hpos_q  <= hpos_d;
      sub_q   <= sub_d;
      hcnt_q  <= hcnt_d;
      ibl_q   <= ibl_d;
      pst_q   <= pst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hbuf_q <= hbuf_d;
  end

endmodule

`default_nettype wire

// ===== sv/ipdf_back.sv =====
`default_nettype none

module ipdf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire ipdf_pkg::job_t head_i,
  output logic                pop_o,
  ipdf_out_if.source          out_o
);
  import ipdf_pkg::*;

  logic [CNT_W-1:0] idx_q, idx_d, total;
  logic             is_byte, last;
  logic [7:0]       sel;

  assign total   = head_i.cnt + CNT_W'(head_i.has_stat);
  assign last    = (idx_q == total - 1'b1);
  assign is_byte = (idx_q < head_i.cnt);

  always_comb begin
    sel = '0;
    for (int i = 0; i < GATHER_MAX; i++) begin
      if (idx_q == CNT_W'(i)) begin
        sel = head_i.data[i];
      end
    end
  end

  assign out_o.valid       = valid_i;
  assign out_o.kind        = is_byte ? KIND_BYTE : KIND_STATUS;
  assign out_o.out_byte    = is_byte ? sel : 8'h00;
  assign out_o.inner_start = is_byte && head_i.start && (idx_q == '0);
  assign out_o.inner_end   = is_byte && head_i.end_last && (idx_q == head_i.cnt - 1'b1);
  assign out_o.inner_is_v6 = is_byte && head_i.v6;
  assign out_o.status      = is_byte ? ST_OK : head_i.stat;
  assign out_o.run_last    = last;

  assign pop_o = valid_i && out_o.ready && last;

  always_comb begin
    idx_d = idx_q;
    if (valid_i && out_o.ready) begin
      idx_d = last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/iptfs_inner_packet_deframer_core.sv =====
`default_nettype none

// Inner-packet deframer for a tunnel payload carried one word (byte) per
// handshake. A word with first set restarts parsing and brings the outer
// length; the outer header is checked, each inner IPv4/IPv6 packet is
// delimited and sent out byte by byte with start and end marks, and every
// outer payload that is not cut off by a restart closes with one status
// word. The parser takes one input word per cycle while the queue has room.
// A word yields up to two results (a body byte plus a status); the word that
// completes an inner header yields up to seven (six header bytes plus a
// status), which the output sequencer sends one per cycle while the output
// is ready. A queue of QueueDepth bursts sits between parser and sequencer,
// so input stalls only once that queue is full, and output back-pressure
// never reaches the input combinationally.

module iptfs_inner_packet_deframer_core #(
  parameter int unsigned QueueDepth = ipdf_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ipdf_in_if.sink    in_i,
  ipdf_out_if.source out_o
);
  import ipdf_pkg::*;

  // Parser to queue
  logic q_push, q_full;
  job_t q_in;

  // Queue to sequencer
  logic q_valid, q_pop;
  job_t q_head;

  // Front: parse outer header, gather inner headers, classify each word
  ipdf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .job_o    (q_in)
  );

  // Hold result bursts so each side can stall on its own
  ipdf_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_head)
  );

  // Back: emit bytes and status one word per cycle while the output is ready
  ipdf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .head_i  (q_head),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Deframer check: outer tunnel payloads go in one word (byte) per handshake,
// and a behavioural model of the parser predicts every result word. Each
// result word that the block hands over is compared field by field with the
// oldest prediction. Both sides idle at random. One phase holds the output
// off for a long stretch so that the internal queue fills and the input
// stalls.

module testbench;
  import ipdf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_WORDS = 100;

  // One result word as the block presents it
  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       inner_start;
    logic       inner_end;
    logic       inner_is_v6;
    status_e    status;
    logic       run_last;
  } deframed_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ipdf_in_if  in_if ();
  ipdf_out_if out_if ();

  iptfs_inner_packet_deframer_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Idling controls, flipped by the tests to get stretches with and without gaps
  bit          src_gaps_on    = 1'b0;
  bit          sink_stalls_on = 1'b0;
  int unsigned hold_off_len   = 0;

  int unsigned fail_count  = 0;
  int unsigned words_sent  = 0;
  int unsigned cycle_count = 0;

  deframed_t  expected_q[$];
  deframed_t  word_results[$];
  logic [7:0] frame_q[$];

  // Parser state of the model
  phase_e      m_phase      = PH_IDLE;
  logic [15:0] m_outer_left = '0;
  int unsigned m_hdr_pos    = 0;
  logic [7:0]  m_subtype    = '0;
  logic [7:0]  m_hdr_buf [GATHER_MAX];
  int unsigned m_gathered   = 0;
  logic [15:0] m_inner_left = '0;
  status_e     m_pending    = ST_OK;

  // ---------------------------------------------------------------------------
  // Model of the parser
  // ---------------------------------------------------------------------------

  // Discard the rest of the outer payload and remember why
  function automatic void abort_outer(input status_e code);
    m_pending = code;
    m_phase   = PH_DROP;
  endfunction

  function automatic void push_inner_byte(input logic [7:0] b, input logic st,
                                          input logic en, input logic v6);
    word_results.push_back('{kind: KIND_BYTE, out_byte: b, inner_start: st,
                             inner_end: en, inner_is_v6: v6, status: ST_OK,
                             run_last: 1'b0});
  endfunction

  // Advance the model by one accepted word and queue the results it causes
  task automatic deframe_word(input logic [7:0] b, input logic f, input logic [15:0] len);
    logic [3:0]  ver;
    int unsigned cnt, room, ip_len, hdr_len;
    logic        v6;
    bit          sized;
    word_results.delete();
    if (f) begin
      // a first word restarts everything, silently abandoning any payload in flight
      m_phase      = PH_HDR;
      m_outer_left = (len == 16'd0) ? 16'd1 : len;
      m_hdr_pos    = 0;
      m_subtype    = '0;
      m_gathered   = 0;
      m_inner_left = '0;
      m_pending    = ST_OK;
    end else if (m_phase == PH_IDLE || m_outer_left == 16'd0) begin
      // stray word outside any payload: ignored
      m_phase = PH_IDLE;
      return;
    end
    m_outer_left--;

    case (m_phase)
      PH_HDR: begin
        if (m_hdr_pos != 0 && b != 8'h00) begin
          abort_outer(ST_BAD_OUTER);
        end else begin
          if (m_hdr_pos == 0) m_subtype = b;
          m_hdr_pos++;
          if (m_hdr_pos == BASIC_HDR_LEN) begin
            if (m_subtype == SUBTYPE_CC) begin
              m_phase = PH_CC;
            end else if (m_subtype == SUBTYPE_BASIC) begin
              m_phase    = PH_GATHER;
              m_gathered = 0;
            end else begin
              abort_outer(ST_BAD_OUTER);
            end
          end
        end
      end
      PH_CC: begin
        // congestion-control bytes are skipped unchecked
        m_hdr_pos++;
        if (m_hdr_pos >= CC_HDR_LEN) begin
          m_phase    = PH_GATHER;
          m_gathered = 0;
        end
      end
      PH_GATHER: begin
        if (m_gathered < GATHER_MAX) m_hdr_buf[m_gathered] = b;
        m_gathered++;
        if (m_gathered >= GATHER_MAX || m_outer_left == 16'd0) begin
          // enough of the inner header is in: decide on version and length
          ver   = m_hdr_buf[0][7:4];
          cnt   = m_gathered;
          room  = cnt + 32'(m_outer_left);
          sized = 1'b0;
          if (ver == VER_IPV4) begin
            if (cnt < 4) begin
              abort_outer(ST_BAD_OUTER);
            end else begin
              ip_len  = 32'({m_hdr_buf[2], m_hdr_buf[3]});
              hdr_len = 32'({m_hdr_buf[0][3:0], 2'b00});
              v6      = 1'b0;
              sized   = 1'b1;
            end
          end else if (ver == VER_IPV6) begin
            if (cnt < 6) begin
              abort_outer(ST_BAD_OUTER);
            end else begin
              ip_len  = 32'({m_hdr_buf[4], m_hdr_buf[5]}) + IPV6_HDR_LEN;
              hdr_len = IPV6_HDR_LEN;
              v6      = 1'b1;
              sized   = 1'b1;
            end
          end else if (ver == VER_PAD) begin
            // padding runs to the end of the outer payload
            m_phase = PH_DROP;
          end else begin
            abort_outer(ST_BAD_VER);
          end
          if (sized) begin
            if (ip_len > room || hdr_len > room) begin
              abort_outer(ST_TOO_LONG);
            end else if (ip_len < hdr_len || ip_len < cnt) begin
              abort_outer(ST_TOO_SHORT);
            end else begin
              for (int unsigned i = 0; i < cnt; i++)
                push_inner_byte(m_hdr_buf[i], i == 0, (i + 1) == ip_len, v6);
              m_inner_left = 16'(ip_len - cnt);
              m_gathered   = 0;
              m_phase      = (m_inner_left == 16'd0) ? PH_GATHER : PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        m_inner_left--;
        push_inner_byte(b, 1'b0, m_inner_left == 16'd0, m_hdr_buf[0][7:4] == VER_IPV6);
        if (m_inner_left == 16'd0) begin
          m_phase    = PH_GATHER;
          m_gathered = 0;
        end
      end
      default: ;
    endcase

    // the last word of an outer payload closes it with a status word
    if (m_outer_left == 16'd0) begin
      if (m_phase == PH_HDR || m_phase == PH_CC) m_pending = ST_BAD_OUTER;
      word_results.push_back('{kind: KIND_STATUS, out_byte: 8'h00, inner_start: 1'b0,
                               inner_end: 1'b0, inner_is_v6: 1'b0, status: m_pending,
                               run_last: 1'b0});
      m_phase = PH_IDLE;
    end

    if (word_results.size() != 0) word_results[$].run_last = 1'b1;
    foreach (word_results[i]) expected_q.push_back(word_results[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Checking and prediction, both on the rising edge
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Check the output word first: it always stems from an earlier input word,
  // so predicting this edge's input word afterwards keeps the order right.
  always @(posedge clk_i) begin
    deframed_t want;
    cycle_count++;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: kind %0d byte %0d status %0d",
                 out_if.kind, out_if.out_byte, out_if.status);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind",        32'(want.kind),        32'(out_if.kind));
          check_field("out_byte",    32'(want.out_byte),    32'(out_if.out_byte));
          check_field("inner_start", 32'(want.inner_start), 32'(out_if.inner_start));
          check_field("inner_end",   32'(want.inner_end),   32'(out_if.inner_end));
          check_field("inner_is_v6", 32'(want.inner_is_v6), 32'(out_if.inner_is_v6));
          check_field("status",      32'(want.status),      32'(out_if.status));
          check_field("run_last",    32'(want.run_last),    32'(out_if.run_last));
        end
      end
      if (in_if.valid && in_if.ready)
        deframe_word(in_if.data_byte, in_if.first, in_if.outer_len);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Offer one word at a falling edge and hold it until it is taken
  task automatic send_word(input logic [7:0] b, input logic f, input logic [15:0] len);
    int unsigned gap;
    gap = (src_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.first     <= f;
    in_if.outer_len <= len;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Send the frame under construction; outer_len is junk on all but the first word
  task automatic send_frame(input int unsigned len);
    foreach (frame_q[i])
      send_word(frame_q[i], i == 0, (i == 0) ? 16'(len) : 16'($urandom_range(0, 65535)));
    frame_q.delete();
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
  endtask

  task automatic put_random(input int unsigned n);
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Tunnel header: subtype, flags, block offset; congestion control adds 20 bytes
  task automatic put_tunnel_hdr(input logic [7:0] subtype);
    frame_q.push_back(subtype);
    repeat (3) frame_q.push_back(8'h00);
    if (subtype == SUBTYPE_CC) put_random(CC_HDR_LEN - BASIC_HDR_LEN);
  endtask

  task automatic put_ipv4(input logic [15:0] total, input logic [3:0] ihl);
    frame_q.push_back({VER_IPV4, ihl});
    put_random(1);
    frame_q.push_back(total[15:8]);
    frame_q.push_back(total[7:0]);
    put_random((total > 16'd4) ? 32'(total) - 4 : 0);
  endtask

  task automatic put_ipv6(input logic [15:0] payload);
    frame_q.push_back({VER_IPV6, 4'($urandom_range(0, 15))});
    put_random(3);
    frame_q.push_back(payload[15:8]);
    frame_q.push_back(payload[7:0]);
    put_random(IPV6_HDR_LEN - 6 + 32'(payload));
  endtask

  task automatic put_pad(input int unsigned n);
    frame_q.push_back({VER_PAD, 4'($urandom_range(0, 15))});
    put_random(n - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_len != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_off_len) @(negedge clk_i);
        hold_off_len = 0;
      end else if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Stray words, short outer lengths including zero, and every kind of header fault
  task automatic test_outer_header();
    send_noise(2);
    frame_q = '{8'h00};
    send_frame(0);                     // zero length behaves as one: header cut short
    put_tunnel_hdr(SUBTYPE_BASIC);
    send_frame(4);                     // payload ends right after the header
    put_tunnel_hdr(SUBTYPE_CC);
    send_frame(24);
    put_tunnel_hdr(SUBTYPE_BASIC);
    send_frame(3);                     // last header byte arrives as a stray word
    put_tunnel_hdr(SUBTYPE_CC);
    frame_q = frame_q[0:11];
    send_frame(10);                    // ends inside the congestion-control bytes
    frame_q = '{8'h02, 8'h00, 8'h00, 8'h00};
    send_frame(4);
    frame_q = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h45, 8'h00};
    send_frame(6);
    frame_q = '{8'h00, 8'h80, 8'h00, 8'h00, 8'h45, 8'h00};
    send_frame(6);                     // flags set
    frame_q = '{8'h00, 8'h00, 8'hFF, 8'h00};
    send_frame(4);                     // block offset high byte
    frame_q = '{8'h00, 8'h00, 8'h00, 8'h01};
    send_frame(4);                     // block offset low byte
  endtask

  // Well-formed inner packets of both versions, back to back and with padding
  task automatic test_inner_packets();
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd20, 4'd5);
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd6, 4'd1);             // ends on its last gathered byte
    put_ipv4(16'd8, 4'd2);
    put_pad(3);
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd6, 4'd1);             // six header bytes and the status on one word
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd4, 4'd1);             // only four bytes left to gather
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_CC);
    put_ipv6(16'd2);
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_BASIC);
    frame_q.push_back(8'h42);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h09);
    repeat (2) frame_q.push_back(8'hFF);
    repeat (3) frame_q.push_back(8'h00);
    send_frame(frame_q.size());
  endtask

  // Inner headers that are cut short, of unknown version, or mis-sized
  task automatic test_inner_errors();
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd20, 4'd5);
    frame_q = frame_q[0:6];            // three IPv4 header bytes only
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv6(16'd0);
    frame_q = frame_q[0:8];            // five IPv6 header bytes only
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_BASIC);
    frame_q.push_back(8'h5A);
    put_random(9);
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_BASIC);
    frame_q.push_back(8'hF0);
    put_random(5);
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd200, 4'd5);
    frame_q = frame_q[0:9];            // length beyond the outer payload
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd20, 4'd15);           // header length beyond the outer payload
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv6(16'd100);
    frame_q = frame_q[0:9];
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd10, 4'd5);            // length below header length
    put_pad(20);
    send_frame(frame_q.size());
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd5, 4'd0);             // length below the gathered byte count
    put_pad(4);
    send_frame(frame_q.size());
  endtask

  // A first word in the middle of a payload drops it without a status word
  task automatic test_restart();
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd30, 4'd5);
    frame_q = frame_q[0:11];
    send_frame(65535);
    frame_q = '{8'h01, 8'h00};
    send_frame(24);                    // restart inside the header
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd20, 4'd5);
    frame_q = frame_q[0:14];
    send_frame(24);                    // restart inside an inner body
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd20, 4'd5);
    send_frame(frame_q.size());
  endtask

  // Hold the output off while the input keeps offering words
  task automatic test_backpressure();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    hold_off_len   = 400;
    put_tunnel_hdr(SUBTYPE_BASIC);
    put_ipv4(16'd20, 4'd5);
    put_ipv4(16'd12, 4'd3);
    send_frame(frame_q.size());
  endtask

  // Mostly well-formed payloads with random content; some damaged or cut
  task automatic test_random_frames();
    int unsigned start_count, total, ihl_max, pick;
    int unsigned len;
    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        src_gaps_on    = 1'($urandom_range(0, 1));
        sink_stalls_on = 1'($urandom_range(0, 1));
      end
      put_tunnel_hdr(($urandom_range(0, 3) == 0) ? SUBTYPE_CC : SUBTYPE_BASIC);
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 5) == 0) begin
          put_ipv6(16'($urandom_range(0, 6)));
        end else begin
          total   = $urandom_range(6, 40);
          ihl_max = (total / 4 > 15) ? 15 : total / 4;
          put_ipv4(16'(total), 4'($urandom_range(0, ihl_max)));
        end
      end
      if ($urandom_range(0, 2) == 0) put_pad($urandom_range(1, 8));
      len  = frame_q.size();
      pick = $urandom_range(0, 9);
      if (pick == 7) begin
        frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick == 8) begin
        len = $urandom_range(1, frame_q.size());            // tail becomes stray words
      end else if (pick == 9) begin
        len = frame_q.size() + $urandom_range(1, 8);        // left open for a restart
      end
      send_frame(len);
      if ($urandom_range(0, 7) == 0) send_noise($urandom_range(1, 3));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.first     = 1'b0;
    in_if.outer_len = 16'h0000;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_outer_header();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    test_inner_packets();
    test_inner_errors();
    test_restart();
    test_backpressure();
    test_random_frames();

    // drain: stop offering, let every predicted word arrive, then watch for extras
    in_if.valid    <= 1'b0;
    sink_stalls_on  = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("iptfs_inner_packet_deframer_core test passed");
    else
      $display("iptfs_inner_packet_deframer_core test failed");
    $finish;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("iptfs_inner_packet_deframer_core test failed");
    $finish;
  end

endmodule
